// File: sv/assert_macros.svh
// Assertion macros shared by the checker files of the keyframe track player.
// Each macro expands to one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/kfp_pkg.sv
// Shared types and constants of the keyframe track player.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package kfp_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned VAL_W      = 32;
    localparam int unsigned DT_W       = 24;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned SPEED_FRAC = 8;
    localparam int unsigned CNT_W      = 5;
    localparam int unsigned FUNC_W     = 3;
    localparam int unsigned KIDX_W     = 4;
    localparam int unsigned ALPHA_W    = 16;
    localparam int unsigned PADDR_W    = 4;
    localparam int unsigned PDATA_W    = 32;

    // Command codes carried by an input transfer.
    localparam logic [FUNC_W-1:0] FUNC_WRITE_KEY = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PLAY      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_PAUSE     = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_STOP      = 3'd4;

    // Playback states as reported on run_state.
    localparam logic [1:0] RUN_STOPPED = 2'd0;
    localparam logic [1:0] RUN_PLAYING = 2'd1;
    localparam logic [1:0] RUN_PAUSED  = 2'd2;

    // End-of-track behaviors.
    localparam logic [1:0] MODE_LOOP     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_KEY_COUNT = 2'd0;
    localparam logic [1:0] REG_PLAY_MODE = 2'd1;
    localparam logic [1:0] REG_SPEED     = 2'd2;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;
    localparam logic [TIME_W-1:0]  TIME_MAX    = '1;

    typedef struct packed {
        logic [CNT_W-1:0]   key_count;
        logic [1:0]         play_mode;
        logic [SPEED_W-1:0] speed_magnitude;
    } kfp_cfg_t;

    typedef struct packed {
        logic [TIME_W-1:0] key_time;
        logic [VAL_W-1:0]  key_value;
    } kfp_key_t;

endpackage

// File: sv/kfp_key_mem.sv
// Keyframe store: one synchronous memory of time/value pairs.
// One write port and one read port with registered read data; uses kfp_pkg.
`timescale 1ns / 1ps

module kfp_key_mem
    import kfp_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  kfp_key_t      wr_data,
    input  logic [AW-1:0] rd_addr,
    output kfp_key_t      rd_data
);

    kfp_key_t key_mem [DEPTH];
    kfp_key_t rd_data_reg;

    // Write first in program order; a read of the entry being written returns old data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= key_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/kfp_alpha_div.sv
// Serial divider for the interpolation weight: floor(num * 2^16 / span), capped.
// One quotient bit per cycle; done pulses together with the last bit reaching alpha; uses kfp_pkg.
`timescale 1ns / 1ps

module kfp_alpha_div
    import kfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TIME_W-1:0]  num,
    input  logic [TIME_W-1:0]  span,
    output logic               done,
    output logic [ALPHA_W-1:0] alpha
);

    localparam int unsigned CW = $clog2(ALPHA_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [TIME_W-1:0]  rem_reg, rem_next;
    logic [TIME_W-1:0]  span_reg, span_next;
    logic [ALPHA_W-1:0] quo_reg, quo_next;
    logic [TIME_W:0]    rem_shift;
    logic [TIME_W:0]    rem_diff;

    // Trial subtraction; the top bit of the difference flags a negative result.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, span_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        span_next = span_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            span_next = span;
            // A numerator that reaches the span would give a weight of one; cap it.
            if (num >= span)
            begin
                quo_next  = '1;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            else
            begin
                rem_next  = num;
                quo_next  = '0;
                cnt_next  = CW'(ALPHA_W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!rem_diff[TIME_W])
            begin
                rem_next = rem_diff[TIME_W-1:0];
                quo_next = {quo_reg[ALPHA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[TIME_W-1:0];
                quo_next = {quo_reg[ALPHA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            span_reg <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            span_reg <= span_next;
            quo_reg  <= quo_next;
        end
    end

    assign done  = done_reg;
    assign alpha = quo_reg;

endmodule

// File: sv/kfp_apb_regs.sv
// Configuration registers of the keyframe track player behind an APB-style port.
// Holds key count, play mode and speed; uses kfp_pkg.
`timescale 1ns / 1ps

module kfp_apb_regs
    import kfp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output kfp_cfg_t           cfg
);

    kfp_cfg_t   cfg_reg, cfg_next;
    logic [1:0] reg_sel;
    logic       wr_xfer;

    assign reg_sel = paddr[PADDR_W-1:2];
    assign wr_xfer = psel & penable & pwrite;

    // Register update on the access phase of a write transfer.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_xfer)
        begin
            case (reg_sel)
                REG_KEY_COUNT: cfg_next.key_count       = pwdata[CNT_W-1:0];
                REG_PLAY_MODE: cfg_next.play_mode       = pwdata[1:0];
                REG_SPEED:     cfg_next.speed_magnitude = pwdata[SPEED_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Read data, zero extended; unmapped addresses read as zero.
    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            REG_KEY_COUNT: prdata[CNT_W-1:0]   = cfg_reg.key_count;
            REG_PLAY_MODE: prdata[1:0]         = cfg_reg.play_mode;
            REG_SPEED:     prdata[SPEED_W-1:0] = cfg_reg.speed_magnitude;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_count       <= '0;
            cfg_reg.play_mode       <= '0;
            cfg_reg.speed_magnitude <= SPEED_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign pready = 1'b1;
    assign cfg    = cfg_reg;

endmodule

// File: sv/keyframe_track_player.sv
// Keyframe track player: one scalar Q16.16 track, linear interpolation between keys.
// A write, play, pause, stop or idle tick goes from decode to the result register;
// a playing tick first reads the last key, then may scan the keys through the single
// memory read port and run the serial weight divider. A stalled output holds results.
// One item is in work at a time. Reset clears time, value, direction and playback
// state at once; the key memory holds nothing defined until its slots are written.
`timescale 1ns / 1ps

module keyframe_track_player
    import kfp_pkg::*;
#(
    parameter int unsigned MAX_KEYS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic [KIDX_W-1:0]        key_index,
    input  logic [TIME_W-1:0]        key_time,
    input  logic signed [VAL_W-1:0]  key_value,
    input  logic [DT_W-1:0]          delta_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [VAL_W-1:0]  value,
    output logic [TIME_W-1:0]        play_time,
    output logic [1:0]               run_state,
    output logic                     reached_end,
    output logic                     reversed
);

    localparam int unsigned AW     = $clog2(MAX_KEYS);
    localparam int unsigned PROD_W = VAL_W + ALPHA_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LEN,
        S_FIRST,
        S_SCAN,
        S_PREP,
        S_DIV,
        S_MULV,
        S_ADDV,
        S_END,
        S_DONE
    } state_t;

    state_t                    state_reg, state_next;
    logic [TIME_W-1:0]         time_reg, time_next;
    logic [1:0]                play_state_reg, play_state_next;
    logic                      backwards_reg, backwards_next;
    logic [VAL_W-1:0]          value_reg, value_next;
    logic [TIME_W-1:0]         step_reg, step_next;
    logic [TIME_W-1:0]         length_reg, length_next;
    logic [VAL_W-1:0]          last_val_reg, last_val_next;
    logic                      hit_reg, hit_next;
    logic                      ended_reg, ended_next;
    logic [CNT_W-1:0]          j_reg, j_next;
    logic [TIME_W-1:0]         t1_reg, t1_next;
    logic [VAL_W-1:0]          v1_reg, v1_next;
    logic [TIME_W-1:0]         t2_reg, t2_next;
    logic [VAL_W-1:0]          v2_reg, v2_next;
    logic signed [VAL_W:0]     diff_reg, diff_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]          out_value_reg, out_value_next;
    logic [TIME_W-1:0]         out_time_reg, out_time_next;
    logic [1:0]                out_state_reg, out_state_next;
    logic                      out_end_reg, out_end_next;
    logic                      out_rev_reg, out_rev_next;

    kfp_cfg_t                  cfg;
    kfp_key_t                  rd_data;
    logic [AW-1:0]             mem_rd_addr;
    logic                      mem_wr_en;
    logic                      in_xfer;
    logic [CNT_W-1:0]          n_keys;
    logic [CNT_W-1:0]          last_idx;
    logic [DT_W+SPEED_W-1:0]   step_prod;
    logic [TIME_W-1:0]         length_sel;
    logic [TIME_W:0]           fwd_sum;
    logic [TIME_W-1:0]         fwd_time;
    logic                      bwd_hit;
    logic [TIME_W-1:0]         span_raw;
    logic [TIME_W-1:0]         div_num;
    logic [TIME_W-1:0]         div_span;
    logic                      div_start;
    logic                      div_done;
    logic [ALPHA_W-1:0]        alpha;
    logic signed [ALPHA_W:0]   alpha_s;

    kfp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kfp_key_mem #(
        .DEPTH (MAX_KEYS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (AW'(key_index)),
        .wr_data ({key_time, key_value}),
        .rd_addr (mem_rd_addr),
        .rd_data (rd_data)
    );

    kfp_alpha_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .span  (div_span),
        .done  (div_done),
        .alpha (alpha)
    );

    // Input transfers are taken only while no item is in work.
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid & in_ready;
    assign mem_wr_en = in_xfer && (func == FUNC_WRITE_KEY) && (32'(key_index) < MAX_KEYS);

    // Key count clamped to the memory depth, and the index of the last key.
    assign n_keys   = (32'(cfg.key_count) > MAX_KEYS) ? CNT_W'(MAX_KEYS) : cfg.key_count;
    assign last_idx = n_keys - 1'b1;

    // Time step in Q16.16: delta time scaled by the Q8.8 speed.
    assign step_prod = delta_time * cfg.speed_magnitude;

    // Advanced time in both directions, using the track length read from memory.
    assign length_sel = (n_keys == '0) ? '0 : rd_data.key_time;
    assign fwd_sum    = {1'b0, time_reg} + {1'b0, step_reg};
    assign fwd_time   = fwd_sum[TIME_W] ? TIME_MAX : fwd_sum[TIME_W-1:0];
    assign bwd_hit    = (step_reg >= time_reg);

    // Divider operands for the segment that holds the current time.
    assign div_num  = time_reg - t1_reg;
    assign span_raw = t2_reg - t1_reg;
    assign div_span = (span_raw == '0) ? TIME_W'(1) : span_raw;
    assign alpha_s  = {1'b0, alpha};

    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        play_state_next = play_state_reg;
        backwards_next  = backwards_reg;
        value_next      = value_reg;
        step_next       = step_reg;
        length_next     = length_reg;
        last_val_next   = last_val_reg;
        hit_next        = hit_reg;
        ended_next      = ended_reg;
        j_next          = j_reg;
        t1_next         = t1_reg;
        v1_next         = v1_reg;
        t2_next         = t2_reg;
        v2_next         = v2_reg;
        diff_next       = diff_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        out_value_next  = out_value_reg;
        out_time_next   = out_time_reg;
        out_state_next  = out_state_reg;
        out_end_next    = out_end_reg;
        out_rev_next    = out_rev_reg;
        mem_rd_addr     = '0;
        div_start       = 1'b0;

        case (state_reg)
            // Decode the command; only a tick while playing enters the long path.
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ended_next = 1'b0;
                    state_next = S_DONE;
                    case (func)
                        FUNC_TICK:
                        begin
                            if (play_state_reg == RUN_PLAYING)
                            begin
                                step_next   = step_prod[SPEED_FRAC +: TIME_W];
                                mem_rd_addr = AW'(last_idx);
                                state_next  = S_LEN;
                            end
                        end
                        FUNC_PLAY:  play_state_next = RUN_PLAYING;
                        FUNC_PAUSE: play_state_next = RUN_PAUSED;
                        FUNC_STOP:
                        begin
                            play_state_next = RUN_STOPPED;
                            time_next       = '0;
                            backwards_next  = 1'b0;
                        end
                        // Key writes go straight to memory; unused codes leave the playback state as it is.
                        default: state_next = S_DONE;
                    endcase
                end
            end

            // Last key arrives: advance the time and note whether an end was hit.
            S_LEN:
            begin
                length_next   = length_sel;
                last_val_next = rd_data.key_value;
                if (backwards_reg)
                begin
                    hit_next  = bwd_hit;
                    time_next = bwd_hit ? '0 : (time_reg - step_reg);
                end
                else
                begin
                    hit_next  = (fwd_time >= length_sel);
                    time_next = fwd_time;
                end
                if (n_keys == '0)
                begin
                    state_next = S_END;
                end
                else
                begin
                    mem_rd_addr = '0;
                    state_next  = S_FIRST;
                end
            end

            // First key: clamp below the first key or above the last.
            S_FIRST:
            begin
                if (time_reg <= rd_data.key_time)
                begin
                    value_next = rd_data.key_value;
                    state_next = S_END;
                end
                else if (time_reg >= length_reg)
                begin
                    value_next = last_val_reg;
                    state_next = S_END;
                end
                else
                begin
                    t1_next     = rd_data.key_time;
                    v1_next     = rd_data.key_value;
                    j_next      = CNT_W'(1);
                    mem_rd_addr = AW'(1);
                    state_next  = S_SCAN;
                end
            end

            // Walk the keys until the first one at or past the current time.
            S_SCAN:
            begin
                if ((rd_data.key_time >= time_reg) || (j_reg == last_idx))
                begin
                    t2_next    = rd_data.key_time;
                    v2_next    = rd_data.key_value;
                    state_next = S_PREP;
                end
                else
                begin
                    t1_next     = rd_data.key_time;
                    v1_next     = rd_data.key_value;
                    j_next      = j_reg + 1'b1;
                    mem_rd_addr = AW'(j_reg + 1'b1);
                end
            end

            // Start the weight division and form the value difference.
            S_PREP:
            begin
                div_start  = 1'b1;
                diff_next  = $signed({v2_reg[VAL_W-1], v2_reg})
                           - $signed({v1_reg[VAL_W-1], v1_reg});
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MULV;
                end
            end

            S_MULV:
            begin
                prod_next  = diff_reg * alpha_s;
                state_next = S_ADDV;
            end

            // The arithmetic shift floors the scaled difference in both signs.
            S_ADDV:
            begin
                value_next = v1_reg + prod_reg[ALPHA_W +: VAL_W];
                state_next = S_END;
            end

            // Apply the end-of-track behavior after the value is found.
            S_END:
            begin
                ended_next = hit_reg;
                if (hit_reg)
                begin
                    case (cfg.play_mode)
                        MODE_LOOP:
                        begin
                            time_next = backwards_reg ? length_reg : '0;
                        end
                        MODE_PINGPONG:
                        begin
                            time_next      = backwards_reg ? '0 : length_reg;
                            backwards_next = ~backwards_reg;
                        end
                        // Play once, and the unused mode code, stop the track.
                        default:
                        begin
                            play_state_next = RUN_STOPPED;
                            time_next       = '0;
                            backwards_next  = 1'b0;
                        end
                    endcase
                end
                state_next = S_DONE;
            end

            // Load the result register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = value_reg;
                    out_time_next  = time_reg;
                    out_state_next = play_state_reg;
                    out_end_next   = ended_reg;
                    out_rev_next   = backwards_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            time_reg       <= '0;
            play_state_reg <= RUN_STOPPED;
            backwards_reg  <= 1'b0;
            value_reg      <= '0;
            step_reg       <= '0;
            length_reg     <= '0;
            last_val_reg   <= '0;
            hit_reg        <= 1'b0;
            ended_reg      <= 1'b0;
            j_reg          <= '0;
            t1_reg         <= '0;
            v1_reg         <= '0;
            t2_reg         <= '0;
            v2_reg         <= '0;
            diff_reg       <= '0;
            prod_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_time_reg   <= '0;
            out_state_reg  <= RUN_STOPPED;
            out_end_reg    <= 1'b0;
            out_rev_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            play_state_reg <= play_state_next;
            backwards_reg  <= backwards_next;
            value_reg      <= value_next;
            step_reg       <= step_next;
            length_reg     <= length_next;
            last_val_reg   <= last_val_next;
            hit_reg        <= hit_next;
            ended_reg      <= ended_next;
            j_reg          <= j_next;
            t1_reg         <= t1_next;
            v1_reg         <= v1_next;
            t2_reg         <= t2_next;
            v2_reg         <= v2_next;
            diff_reg       <= diff_next;
            prod_reg       <= prod_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_time_reg   <= out_time_next;
            out_state_reg  <= out_state_next;
            out_end_reg    <= out_end_next;
            out_rev_reg    <= out_rev_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value       = out_value_reg;
    assign play_time   = out_time_reg;
    assign run_state   = out_state_reg;
    assign reached_end = out_end_reg;
    assign reversed    = out_rev_reg;

endmodule

// File: sv/kfp_checker.sv
// Port-level checks of the keyframe track player and the bind that attaches them.
// Depends on kfp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kfp_checker
    import kfp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [VAL_W-1:0] value,
    input logic [TIME_W-1:0]       play_time,
    input logic [1:0]              run_state,
    input logic                    reached_end,
    input logic                    reversed
);

    // A result that is not taken stays on the port unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value) && $stable(play_time) && $stable(run_state) && $stable(reached_end) && $stable(reversed), "stalled result changed")

    // A stopped track always sits at time zero, playing forward.
    `ASSERT_IMPLIES(a_stopped_home, clk, rst_n, out_valid && (run_state == RUN_STOPPED), (play_time == '0) && !reversed, "stopped track not at time zero going forward")

    // An end hit that leaves the track playing forward restarts it at time zero.
    `ASSERT_IMPLIES(a_end_forward, clk, rst_n, out_valid && reached_end && (run_state == RUN_PLAYING) && !reversed, play_time == '0, "forward restart not at time zero")

    // An end hit only happens while playing, so it never leaves the track paused.
    `ASSERT_IMPLIES(a_end_not_paused, clk, rst_n, out_valid && reached_end, run_state != RUN_PAUSED, "end hit reported while paused")

endmodule

bind keyframe_track_player kfp_checker u_kfp_checker (.*);
